FILE: src/cpg_pkg.sv
`default_nettype none

package cpg_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE         = 3'd0,
    CFG_START_INC    = 3'd1,
    CFG_CHIRP_STEP   = 3'd2,
    CFG_GROWTH_RATIO = 3'd3,
    CFG_SWEEP_TICKS  = 3'd4,
    CFG_PULSE_WIDTH  = 3'd5,
    CFG_THRESHOLD    = 3'd6
  } cfg_idx_e;

  localparam int unsigned TICK_BITS = 21;
  localparam int unsigned PWIDTH_BITS = 4;
  localparam int unsigned THRESH_BITS = 16;

  // fixed point constants of the sine table build
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic restart;
  } in_word_t;

  typedef struct packed {
    logic pulse;
    logic active;
    logic last_sample;
  } out_word_t;

endpackage

`default_nettype wire

FILE: src/cpg_stream_if.sv
`default_nettype none

interface cpg_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/chirp_pulse_train_generator.sv
`default_nettype none

// Chirp pulse train generator: one input word per sample tick gives one result word
// (pulse, active, last_sample), registered into the output buffer. A word can be
// accepted in every cycle while the skid entry is free; the accumulator, the increment
// update and the threshold crossing all settle in the cycle of acceptance, and the sine
// of the next phase is read ahead from a quarter-wave ram so it is ready for the
// following word. Results pass through a two-word output buffer, so the input keeps
// taking words while one result waits. After reset the quarter table is copied into
// the ram; the input is not ready during that pass, configuration writes are taken
// throughout. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i and takes
// effect on the next tick.

module chirp_pulse_train_generator #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned SINE_TABLE_BITS = 12,
  parameter int unsigned SINE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [cpg_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [cpg_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  cpg_stream_if.sink                               in_i,
  cpg_stream_if.source                             out_o
);
  import cpg_pkg::*;

  localparam int unsigned CmpBits = SINE_BITS + 16;

  // configuration registers
  logic                          mode_q;
  logic [31:0]                   start_inc_q;
  logic [31:0]                   chirp_step_q;
  logic [31:0]                   growth_ratio_q;
  logic [TICK_BITS-1:0]          sweep_ticks_q;
  logic [PWIDTH_BITS-1:0]        pulse_width_q;
  logic signed [THRESH_BITS-1:0] threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      start_inc_q    <= 32'd171798692;
      chirp_step_q   <= 32'd0;
      growth_ratio_q <= 32'd1073741824;
      sweep_ticks_q  <= 21'd1000;
      pulse_width_q  <= 4'd2;
      threshold_q    <= 16'sd26214;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:         mode_q <= cfg_data_i[0];
        CFG_START_INC:    start_inc_q <= cfg_data_i;
        CFG_CHIRP_STEP:   chirp_step_q <= cfg_data_i;
        CFG_GROWTH_RATIO: growth_ratio_q <= cfg_data_i;
        CFG_SWEEP_TICKS:  sweep_ticks_q <= cfg_data_i[TICK_BITS-1:0];
        CFG_PULSE_WIDTH:  pulse_width_q <= cfg_data_i[PWIDTH_BITS-1:0];
        CFG_THRESHOLD:    threshold_q <= signed'(cfg_data_i[THRESH_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // sweep state
  logic [PHASE_BITS-1:0]       phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0]       phase_step_q, phase_step_d;
  logic signed [SINE_BITS-1:0] prev_sine_q, prev_sine_d;
  logic [PWIDTH_BITS-1:0]      pulse_left_q, pulse_left_d;
  logic [TICK_BITS-1:0]        tick_q, tick_d;
  logic                        running_q, running_d;

  logic signed [SINE_BITS-1:0] sine;
  logic                        sine_ready;

  cpg_sine #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SINE_BITS       (SINE_BITS)
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .phase_i (phase_acc_d),
    .sine_o  (sine),
    .ready_o (sine_ready)
  );

  // s * 2^15 > t * 2^(SINE_BITS-1), compared at a common scale
  function automatic logic above(input logic signed [SINE_BITS-1:0] s,
                                 input logic signed [THRESH_BITS-1:0] t);
    logic signed [CmpBits-1:0] a;
    logic signed [CmpBits-1:0] b;
    a = CmpBits'(s) <<< 15;
    b = CmpBits'(t) <<< (SINE_BITS - 1);
    return a > b;
  endfunction

  // output buffer
  out_word_t out_word_q, skid_word_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_fire, out_pop;
  out_word_t res;

  assign in_i.ready = sine_ready & ~skid_valid_q;
  assign in_fire = in_i.valid & in_i.ready;
  assign out_pop = out_valid_q & out_o.ready;

  // per-tick datapath
  logic                        restart;
  logic [PHASE_BITS-1:0]       cur_acc, cur_step;
  logic signed [SINE_BITS-1:0] cur_prev, cur_sine;
  logic [PWIDTH_BITS-1:0]      cur_left, width;
  logic [TICK_BITS-1:0]        cur_tick, len;
  logic                        cur_run;
  logic [PHASE_BITS+31:0]      start_wide, chirp_wide, prod;
  logic [PHASE_BITS-1:0]       grown, lin_step;
  logic                        pulse, last;

  assign restart = in_i.data.restart;
  assign start_wide = (PHASE_BITS+32)'(start_inc_q);
  assign chirp_wide = (PHASE_BITS+32)'(signed'(chirp_step_q));

  assign cur_acc  = restart ? '0 : phase_acc_q;
  assign cur_step = restart ? start_wide[PHASE_BITS-1:0] : phase_step_q;
  assign cur_prev = restart ? '0 : prev_sine_q;
  assign cur_left = restart ? '0 : pulse_left_q;
  assign cur_tick = restart ? '0 : tick_q;
  assign cur_run  = restart | running_q;
  // sine of phase zero is zero
  assign cur_sine = restart ? '0 : sine;

  assign len   = (sweep_ticks_q == '0) ? TICK_BITS'(1) : sweep_ticks_q;
  assign width = (pulse_width_q == '0) ? PWIDTH_BITS'(1) : pulse_width_q;

  // exponential law saturates at the full phase range
  assign prod = (PHASE_BITS+32)'(cur_step) * (PHASE_BITS+32)'(growth_ratio_q);
  assign grown = (|prod[PHASE_BITS+31:PHASE_BITS+30]) ? '1 : prod[PHASE_BITS+29:30];
  assign lin_step = cur_step - chirp_wide[PHASE_BITS-1:0];

  always_comb begin
    phase_acc_d  = phase_acc_q;
    phase_step_d = phase_step_q;
    prev_sine_d  = prev_sine_q;
    pulse_left_d = pulse_left_q;
    tick_d       = tick_q;
    running_d    = running_q;
    pulse        = 1'b0;
    last         = 1'b0;
    if (in_fire && cur_run) begin
      pulse_left_d = cur_left;
      if (cur_left != '0) begin
        pulse        = 1'b1;
        pulse_left_d = cur_left - 1'b1;
      end else if (cur_tick < len && above(cur_sine, threshold_q)
                   && !above(cur_prev, threshold_q)) begin
        pulse        = 1'b1;
        pulse_left_d = width - 1'b1;
      end
      prev_sine_d  = cur_sine;
      phase_acc_d  = cur_acc + cur_step;
      phase_step_d = mode_q ? grown : lin_step;
      tick_d       = (cur_tick == '1) ? cur_tick : cur_tick + 1'b1;
      last         = (tick_d >= len) && (pulse_left_d == '0);
      running_d    = ~last;
    end
  end

  assign res.pulse       = pulse;
  assign res.active      = cur_run;
  assign res.last_sample = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q  <= '0;
      phase_step_q <= '0;
      prev_sine_q  <= '0;
      pulse_left_q <= '0;
      tick_q       <= '0;
      running_q    <= 1'b0;
    end else begin
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      prev_sine_q  <= prev_sine_d;
      pulse_left_q <= pulse_left_d;
      tick_q       <= tick_d;
      running_q    <= running_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_q || out_pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_pop) begin
        out_word_q <= res;
      end else begin
        skid_word_q <= res;
      end
    end else if (out_pop && skid_valid_q) begin
      out_word_q <= skid_word_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

  // a pulse only comes out of a running sweep
  a_pulse_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.pulse |-> out_o.data.active)
    else $error("pulse without active");

  // the final word of a sweep stops it
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res.last_sample |=> !running_q)
    else $error("sweep still running after last sample");

  // a trailing pulse keeps the sweep alive
  a_left_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_left_q != '0 |-> running_q)
    else $error("pulse pending while idle");

  // no word is taken before the sine table is loaded
  a_fill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sine_ready |-> !in_i.ready)
    else $error("input ready during table fill");

  // the skid entry is only used behind a full output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without output word");
endmodule

`default_nettype wire

FILE: src/cpg_ram.sv
`default_nettype none

module cpg_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

`default_nettype wire

FILE: src/cpg_sine.sv
`default_nettype none

module cpg_sine #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned SINE_TABLE_BITS = 12,
  parameter int unsigned SINE_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [PHASE_BITS-1:0]       phase_i,
  output logic signed [SINE_BITS-1:0]      sine_o,
  output logic                             ready_o
);
  import cpg_pkg::*;

  localparam int unsigned QAddrBits = SINE_TABLE_BITS - 2;
  localparam int unsigned QDepth = 2 ** QAddrBits;

  typedef logic [SINE_BITS-2:0] mag_t;
  typedef mag_t rom_t [QDepth];

  function automatic longint unsigned taylor_div(input longint unsigned t, input int k);
    longint unsigned q;
    case (k)
      1:       q = t / 6;
      2:       q = t / 20;
      3:       q = t / 42;
      4:       q = t / 72;
      5:       q = t / 110;
      6:       q = t / 156;
      default: q = t / 210;
    endcase
    return q;
  endfunction

  // quarter-wave magnitude, taylor series to the x^15 term in q1.30
  function automatic mag_t sine_mag(input int unsigned f);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned amp;
    longint unsigned mag;
    longint sum;
    x = (longint'(f) * HALF_PI_Q30) >> QAddrBits;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      term = taylor_div(term, k);
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    amp = (64'd1 << (SINE_BITS - 1)) - 64'd1;
    mag = (longint'(sum) * amp + (64'd1 << 29)) >> 30;
    return mag[SINE_BITS-2:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < QDepth; i++) begin
      r[i] = sine_mag(i);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();
  localparam mag_t SinePeak = sine_mag(QDepth);

  // fill sequencer: copies the quarter table into the ram after reset
  logic [QAddrBits:0] fill_cnt_q, fill_cnt_d;
  logic               done_q;
  logic               fill_we;

  assign fill_we = ~fill_cnt_q[QAddrBits];
  assign fill_cnt_d = fill_we ? fill_cnt_q + 1'b1 : fill_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      fill_cnt_q <= fill_cnt_d;
      done_q     <= fill_cnt_q[QAddrBits];
    end
  end

  assign ready_o = done_q;

  // quadrant fold of the table address
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QAddrBits-1:0]       f_raw;
  logic [QAddrBits:0]         f_fold;
  logic [QAddrBits-1:0]       raddr;
  logic                       peak;
  logic                       sign_q;
  logic                       peak_q;
  mag_t                       rdata;
  mag_t                       mag;
  logic signed [SINE_BITS-1:0] mag_ext;

  assign idx = phase_i[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign f_raw = idx[QAddrBits-1:0];
  assign f_fold = quad[0] ? (QAddrBits+1)'(QDepth) - {1'b0, f_raw} : {1'b0, f_raw};
  assign raddr = f_fold[QAddrBits-1:0];
  assign peak = f_fold[QAddrBits];

  always_ff @(posedge clk_i) begin
    sign_q <= quad[1];
    peak_q <= peak;
  end

  cpg_ram #(
    .WIDTH (SINE_BITS - 1),
    .DEPTH (QDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_cnt_q[QAddrBits-1:0]),
    .wdata_i (SineRom[fill_cnt_q[QAddrBits-1:0]]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mag = peak_q ? SinePeak : rdata;
  assign mag_ext = signed'({1'b0, mag});
  assign sine_o = sign_q ? -mag_ext : mag_ext;
endmodule

`default_nettype wire
